// ----- rtl/pfc_pkg.sv -----
`default_nettype none

package pfc_pkg;

  localparam int unsigned PixelWidth    = 32;
  localparam int unsigned FmtWidth      = 4;
  localparam int unsigned CountWidth    = 3;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 4;
  localparam int unsigned FmtCount      = 9;

  typedef enum logic [FmtWidth-1:0] {
    FMT_ARGB32     = 4'd0,
    FMT_RGBA32     = 4'd1,
    FMT_RGB24      = 4'd2,
    FMT_RGB565     = 4'd3,
    FMT_RGBA5551   = 4'd4,
    FMT_MONO       = 4'd5,
    FMT_MONO_ALPHA = 4'd6,
    FMT_BGRA32     = 4'd7,
    FMT_BGR24      = 4'd8
  } fmt_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_SOURCE_FORMAT = 2'd0,
    CFG_TARGET_FORMAT = 2'd1,
    CFG_SWAP_BYTES    = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // unknown codes fall back to argb32
  function automatic fmt_e valid_fmt(input logic [FmtWidth-1:0] code);
    fmt_e f;
    if (code < FmtWidth'(FmtCount)) begin
      f = fmt_e'(code);
    end else begin
      f = FMT_ARGB32;
    end
    return f;
  endfunction

  function automatic logic [CountWidth-1:0] fmt_bytes(input fmt_e f);
    logic [CountWidth-1:0] n;
    unique case (f)
      FMT_RGB24, FMT_BGR24:                      n = 3'd3;
      FMT_RGB565, FMT_RGBA5551, FMT_MONO_ALPHA:  n = 3'd2;
      FMT_MONO:                                  n = 3'd1;
      default:                                   n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [PixelWidth-1:0] byte_mask(input logic [CountWidth-1:0] n);
    logic [PixelWidth-1:0] m;
    unique case (n)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pfc_decode.sv -----
`default_nettype none

module pfc_decode (
  input  var pfc_pkg::fmt_e                     fmt_i,
  input  var logic                              swap_i,
  input  var logic [pfc_pkg::PixelWidth-1:0]    pixel_i,
  output var pfc_pkg::rgba_t                    rgba_o
);
  import pfc_pkg::*;

  logic [7:0] b0, b1, b2, b3;
  logic [7:0] hi, lo;

  assign b0 = pixel_i[7:0];
  assign b1 = pixel_i[15:8];
  assign b2 = pixel_i[23:16];
  assign b3 = pixel_i[31:24];
  assign hi = swap_i ? b1 : b0;
  assign lo = swap_i ? b0 : b1;

  always_comb begin
    unique case (fmt_i)
      FMT_RGBA32:     rgba_o = '{r: b0, g: b1, b: b2, a: b3};
      FMT_RGB24:      rgba_o = '{r: b0, g: b1, b: b2, a: 8'hff};
      FMT_RGB565: begin
        rgba_o = '{r: {hi[7:3], 3'b000}, g: {hi[2:0], lo[7:5], 2'b00},
                   b: {lo[4:0], 3'b000}, a: 8'hff};
      end
      FMT_RGBA5551: begin
        rgba_o = '{r: {hi[7:3], 3'b000}, g: {hi[2:0], lo[7:6], 3'b000},
                   b: {lo[5:1], 3'b000}, a: {8{lo[0]}}};
      end
      FMT_MONO:       rgba_o = '{r: b0, g: b0, b: b0, a: 8'hff};
      FMT_MONO_ALPHA: rgba_o = '{r: b0, g: b0, b: b0, a: b1};
      FMT_BGRA32:     rgba_o = '{r: b2, g: b1, b: b0, a: b3};
      FMT_BGR24:      rgba_o = '{r: b2, g: b1, b: b0, a: 8'hff};
      default:        rgba_o = '{r: b1, g: b2, b: b3, a: b0};
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/pfc_encode.sv -----
`default_nettype none

module pfc_encode (
  input  var pfc_pkg::fmt_e                     fmt_i,
  input  var logic                              swap_i,
  input  var pfc_pkg::rgba_t                    rgba_i,
  output var logic [pfc_pkg::PixelWidth-1:0]    pixel_o
);
  import pfc_pkg::*;

  logic [15:0] luma_sum;
  logic [7:0]  luma;
  logic [7:0]  hi16;
  logic [7:0]  lo565, lo5551;
  logic [15:0] word565, word5551;

  // bt.601 luma
  assign luma_sum = 16'(16'd66 * rgba_i.r) + 16'(16'd129 * rgba_i.g)
                  + 16'(16'd25 * rgba_i.b) + 16'd128;
  assign luma     = luma_sum[15:8] + 8'd16;

  assign hi16     = {rgba_i.r[7:3], rgba_i.g[7:5]};
  assign lo565    = {rgba_i.g[4:2], rgba_i.b[7:3]};
  assign lo5551   = {rgba_i.g[4:3], rgba_i.b[7:3], rgba_i.a[7]};
  assign word565  = swap_i ? {hi16, lo565} : {lo565, hi16};
  assign word5551 = swap_i ? {hi16, lo5551} : {lo5551, hi16};

  always_comb begin
    unique case (fmt_i)
      FMT_RGBA32:     pixel_o = {rgba_i.a, rgba_i.b, rgba_i.g, rgba_i.r};
      FMT_RGB24:      pixel_o = {8'h00, rgba_i.b, rgba_i.g, rgba_i.r};
      FMT_RGB565:     pixel_o = {16'h0000, word565};
      FMT_RGBA5551:   pixel_o = {16'h0000, word5551};
      FMT_MONO:       pixel_o = {24'h000000, luma};
      FMT_MONO_ALPHA: pixel_o = {16'h0000, rgba_i.a, luma};
      FMT_BGRA32:     pixel_o = {rgba_i.a, rgba_i.r, rgba_i.g, rgba_i.b};
      FMT_BGR24:      pixel_o = {8'h00, rgba_i.r, rgba_i.g, rgba_i.b};
      default:        pixel_o = {rgba_i.b, rgba_i.g, rgba_i.r, rgba_i.a};
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/pixel_format_converter.sv -----
// pixel_format_converter
// converts one pixel between nine byte formats (argb32, rgba32, rgb24,
// rgb565, rgba5551, mono, mono+alpha, bgra32, bgr24), mono targets by bt.601
// luma. equal source and target formats copy the pixel bytes unchanged.
// input: a transfer happens on a clock edge with start_i high and busy_o low.
// busy_o is always low, so one pixel can be taken every cycle.
// output: done_o is high for exactly one cycle with target_pixel_o and
// target_byte_count_o; the receiver cannot stall, the result must be taken.
// pipeline: the input transfer loads the input register, the decode and
// encode logic works on it, and the result register then holds the result
// with done_o high; throughput one pixel per cycle, set by the single
// decode/encode pass between the two registers.
// configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 source format, 1 target format, 2 16-bit byte swap); write only while
// no pixel is in flight.
// reset: rst_ni low clears both pipeline valids and sets formats to argb32
// and byte swap to 1.
`default_nettype none

module pixel_format_converter (
  input  var logic                                clk_i,
  input  var logic                                rst_ni,
  input  var logic                                start_i,
  output var logic                                busy_o,
  input  var logic [pfc_pkg::PixelWidth-1:0]      source_pixel_i,
  output var logic                                done_o,
  output var logic [pfc_pkg::PixelWidth-1:0]      target_pixel_o,
  output var logic [pfc_pkg::CountWidth-1:0]      target_byte_count_o,
  input  var logic                                cfg_we_i,
  input  var logic [pfc_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  var logic [pfc_pkg::CfgDataWidth-1:0]    cfg_wdata_i
);
  import pfc_pkg::*;

  logic [FmtWidth-1:0]   src_fmt_q, tgt_fmt_q;
  logic                  swap_q;
  logic                  in_valid_q;
  logic [PixelWidth-1:0] in_pixel_q;
  logic                  done_q;
  logic [PixelWidth-1:0] out_pixel_q, out_pixel_d;
  logic [CountWidth-1:0] out_count_q, out_count_d;
  fmt_e                  src_fmt, tgt_fmt;
  rgba_t                 rgba;
  logic [PixelWidth-1:0] enc_pixel;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= FmtWidth'(FMT_ARGB32);
      tgt_fmt_q <= FmtWidth'(FMT_ARGB32);
      swap_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SOURCE_FORMAT: src_fmt_q <= cfg_wdata_i[FmtWidth-1:0];
        CFG_TARGET_FORMAT: tgt_fmt_q <= cfg_wdata_i[FmtWidth-1:0];
        CFG_SWAP_BYTES:    swap_q    <= cfg_wdata_i[0];
        default:           ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_pixel_q <= source_pixel_i;
    end
  end

  assign src_fmt = valid_fmt(src_fmt_q);
  assign tgt_fmt = valid_fmt(tgt_fmt_q);

  pfc_decode u_decode (
    .fmt_i   (src_fmt),
    .swap_i  (swap_q),
    .pixel_i (in_pixel_q),
    .rgba_o  (rgba)
  );

  pfc_encode u_encode (
    .fmt_i   (tgt_fmt),
    .swap_i  (swap_q),
    .rgba_i  (rgba),
    .pixel_o (enc_pixel)
  );

  always_comb begin
    out_count_d = fmt_bytes(tgt_fmt);
    if (src_fmt == tgt_fmt) begin
      out_pixel_d = in_pixel_q & byte_mask(out_count_d);
    end else begin
      out_pixel_d = enc_pixel & byte_mask(out_count_d);
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      out_pixel_q <= out_pixel_d;
      out_count_q <= out_count_d;
    end
  end

  assign done_o              = done_q;
  assign target_pixel_o      = out_pixel_q;
  assign target_byte_count_o = out_count_q;

endmodule

`default_nettype wire
